>>> hw/rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types, widths and character classes for the text motion landing
// scanner.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 12;

    // item kinds carried in the action field
    localparam logic ACT_CHAR       = 1'b0;
    localparam logic ACT_EMPTY_LINE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
        logic [7:0] lookahead_ch;
        logic       last_in_line;
    } char_item_t;

    typedef struct packed {
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic                   word_begin;
        logic                   word_end;
        logic                   big_word_begin;
        logic                   big_word_end;
        logic                   sentence_start;
        logic                   paragraph_mark;
    } mark_item_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) ||
               ((c >= 8'h41) && (c <= 8'h5a)) ||
               ((c >= 8'h30) && (c <= 8'h39)) ||
               (c == 8'h5f);
    endfunction

    function automatic logic is_sentence_end(input logic [7:0] c);
        return (c == 8'h2e) || (c == 8'h21) || (c == 8'h3f);
    endfunction

endpackage

>>> hw/rtl/text_motion_landing_scanner_core.sv
// ----------------------------------------------------------------------------
// text_motion_landing_scanner_core
// Marks word, WORD, sentence and paragraph landings for a character stream.
// ----------------------------------------------------------------------------
//  channel | signals                            | payload
//  --------+------------------------------------+-------------
//  input   | char_valid, char_stall (out)       | char_item_t
//  output  | mark_valid (out), mark_stall       | mark_item_t
//
// one item per cycle sustained while mark_stall is low; each item passes
// an input register, the scan logic and a result register. reset clears
// both valid flags and sets all scan state to its initial values.
// char_stall follows mark_stall within the cycle when both registers are full;
// a waiting result blocks new items only once the input register is full too.
// ----------------------------------------------------------------------------
module text_motion_landing_scanner_core
    import tms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_item_t char_item,
    output logic       mark_valid,
    input  logic       mark_stall,
    output mark_item_t mark_item
);

    logic       in_valid_reg;
    char_item_t in_item_reg;
    logic       out_valid_reg;
    mark_item_t out_item_reg;
    mark_item_t scan_result;
    logic       out_ready;
    logic       advance;

    assign out_ready  = !out_valid_reg || !mark_stall;
    assign advance    = in_valid_reg && out_ready;
    assign char_stall = in_valid_reg && !out_ready;
    assign mark_valid = out_valid_reg;
    assign mark_item  = out_item_reg;

    tms_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!char_stall)
                in_valid_reg <= char_valid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            in_item_reg <= char_item;
        if (advance)
            out_item_reg <= scan_result;
    end

endmodule

>>> hw/rtl/tms_scan.sv
// ----------------------------------------------------------------------------
// tms_scan
// Scan state (position, previous character, sentence and paragraph history)
// and the landing-mark logic for one item.
// ----------------------------------------------------------------------------
module tms_scan
    import tms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  char_item_t item,
    output mark_item_t result
);

    logic [7:0]             prev_char_reg, prev_char_next;
    logic                   pending_reg, pending_next;
    logic                   prev_blank_reg, prev_blank_next;
    logic                   has_nonblank_reg, has_nonblank_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;

    logic at_start;
    logic cb;
    logic cw;
    logic cs;
    logic p_word;
    logic p_big;
    logic n_word;
    logic n_blank;
    logic n_big;
    logic blank_line;
    logic [LINE_BITS-1:0] line_inc;

    always_comb
    begin
        at_start   = (column_reg == '0);
        cb         = is_blank(item.ch);
        cw         = is_word(item.ch);
        cs         = is_sentence_end(item.ch);
        p_word     = !at_start && is_word(prev_char_reg);
        p_big      = !at_start && !is_blank(prev_char_reg);
        n_word     = !item.last_in_line && is_word(item.lookahead_ch);
        n_blank    = !item.last_in_line && is_blank(item.lookahead_ch);
        n_big      = !item.last_in_line && !is_blank(item.lookahead_ch);
        blank_line = !has_nonblank_reg && cb;
        line_inc   = (line_reg == '1) ? line_reg : line_reg + 1'b1;

        result            = '0;
        result.line       = line_reg;
        prev_char_next    = prev_char_reg;
        pending_next      = pending_reg;
        prev_blank_next   = prev_blank_reg;
        has_nonblank_next = has_nonblank_reg;
        line_next         = line_reg;
        column_next       = column_reg;

        if (item.action == ACT_EMPTY_LINE)
        begin
            result.paragraph_mark = 1'b1;
            pending_next          = 1'b0;
            prev_blank_next       = 1'b1;
            line_next             = line_inc;
            column_next           = '0;
            has_nonblank_next     = 1'b0;
            prev_char_next        = '0;
        end
        else
        begin
            result.column         = column_reg;
            result.word_begin     = cw && !p_word;
            result.word_end       = cw && !n_word;
            result.big_word_begin = !cb && !p_big;
            result.big_word_end   = !cb && !n_big;
            result.sentence_start = pending_reg && !cb;

            if (cs && (item.last_in_line || n_blank))
                pending_next = 1'b1;
            else if (!cb || pending_reg)
                pending_next = pending_reg && cb;

            if (item.last_in_line)
            begin
                result.paragraph_mark = blank_line || prev_blank_reg;
                prev_blank_next       = blank_line;
                line_next             = line_inc;
                column_next           = '0;
                has_nonblank_next     = 1'b0;
                prev_char_next        = '0;
            end
            else
            begin
                has_nonblank_next = has_nonblank_reg || !cb;
                column_next       = (column_reg == '1) ? column_reg : column_reg + 1'b1;
                prev_char_next    = item.ch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_char_reg    <= '0;
            pending_reg      <= 1'b0;
            prev_blank_reg   <= 1'b1;
            has_nonblank_reg <= 1'b0;
            line_reg         <= '0;
            column_reg       <= '0;
        end
        else if (advance)
        begin
            prev_char_reg    <= prev_char_next;
            pending_reg      <= pending_next;
            prev_blank_reg   <= prev_blank_next;
            has_nonblank_reg <= has_nonblank_next;
            line_reg         <= line_next;
            column_reg       <= column_next;
        end
    end

endmodule
